/* rtl/imucf_pkg.sv */
// ----------------------------------------------------------------------------
// imucf_pkg
// Shared types and constants of the complementary attitude filter.
// ----------------------------------------------------------------------------
package imucf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_W     = 54;
    localparam int QUO_W     = 25;
    localparam int CNT_W     = 5;

    localparam logic [15:0] STEP_WEIGHT_RST = 16'd655;

    typedef enum logic [1:0] {
        REG_STEP_WEIGHT,
        REG_BIAS_X,
        REG_BIAS_Y,
        REG_BIAS_Z
    } t_reg_idx;

    // one sample after intake: accel raw, gyro with bias removed
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [16:0] gx;
        logic signed [16:0] gy;
        logic signed [16:0] gz;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] dsh;
        logic [CNT_W-1:0] iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQB,
        S_SQC,
        S_SQSUM,
        S_SQRT,
        S_MD,
        S_DD,
        S_MM,
        S_DEN,
        S_TWAIT,
        S_RD0,
        S_RD1,
        S_RD2,
        S_GM,
        S_GDIV,
        S_GWAIT,
        S_GSUM,
        S_B0,
        S_B1,
        S_B2,
        S_UPD
    } t_state;

endpackage

/* rtl/imucf_top.sv */
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top
// Six-axis IMU attitude estimator with a complementary filter.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) takes one raw sample: accel xyz and gyro
// xyz, signed 16 bits each. Output channel (o_valid / i_ready) gives roll,
// pitch and yaw in signed Q15.16 degrees, one result per sample, in order.
// The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes step weight and
// gyro biases, one per write; write it only while no sample is in flight.
// Samples land in a two-entry queue, so intake runs ahead of the compute
// sequencer. The sequencer picks each sample up; per tilt angle it runs 16
// exact square root steps, a division on the shared bit-serial divider and
// the rest on the shared multiplier; per gyro axis it scales by a reciprocal
// multiply; then it blends and updates. It works on one sample at a time,
// while the queue goes on taking new samples from intake.
// The result sits in the output register until taken; the sequencer holds
// the next sample at its final step while the receiver stalls, and intake
// keeps accepting until the queue is full. Reset clears stored angles, the
// first-sample latch, the queue and config (step weight back to 655).
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x_raw,
    input  logic signed [15:0] i_accel_y_raw,
    input  logic signed [15:0] i_accel_z_raw,
    input  logic signed [15:0] i_gyro_x_raw,
    input  logic signed [15:0] i_gyro_y_raw,
    input  logic signed [15:0] i_gyro_z_raw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_angle_roll,
    output logic signed [31:0] o_angle_pitch,
    output logic signed [31:0] o_angle_yaw,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import imucf_pkg::*;

    logic [15:0]        r_step_weight;
    logic signed [15:0] r_bias_x;
    logic signed [15:0] r_bias_y;
    logic signed [15:0] r_bias_z;

    t_push    push;
    t_q_stat  q_stat;
    t_item    head;
    logic     pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_weight <= STEP_WEIGHT_RST;
            r_bias_x      <= '0;
            r_bias_y      <= '0;
            r_bias_z      <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_STEP_WEIGHT: r_step_weight <= i_cfg_data;
                REG_BIAS_X:      r_bias_x      <= i_cfg_data;
                REG_BIAS_Y:      r_bias_y      <= i_cfg_data;
                REG_BIAS_Z:      r_bias_z      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imucf_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_accel_x_raw (i_accel_x_raw),
        .i_accel_y_raw (i_accel_y_raw),
        .i_accel_z_raw (i_accel_z_raw),
        .i_gyro_x_raw  (i_gyro_x_raw),
        .i_gyro_y_raw  (i_gyro_y_raw),
        .i_gyro_z_raw  (i_gyro_z_raw),
        .i_bias_x      (r_bias_x),
        .i_bias_y      (r_bias_y),
        .i_bias_z      (r_bias_z),
        .i_q_stat      (q_stat),
        .o_push        (push)
    );

    imucf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    imucf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    imucf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step_weight (r_step_weight),
        .i_head        (head),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_div_req     (div_req),
        .i_div_rsp     (div_rsp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_angle_roll  (o_angle_roll),
        .o_angle_pitch (o_angle_pitch),
        .o_angle_yaw   (o_angle_yaw)
    );

    // a full queue never reports empty and never takes a transaction
    a_q_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> (!q_stat.empty && !push.valid))
        else $error("queue full but still pushed or empty");

    // divider done is a single-cycle pulse
    a_div_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held for more than one cycle");

    // divider start is never asserted back to back
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_req.start)
        else $error("back-to-back divider start");

    // result valid drops out of reset
    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

/* rtl/imucf_front.sv */
// ----------------------------------------------------------------------------
// imucf_front
// Sample intake: accepts raw readings, removes gyro bias, pushes to queue.
// ----------------------------------------------------------------------------
module imucf_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [15:0]    i_accel_x_raw,
    input  logic signed [15:0]    i_accel_y_raw,
    input  logic signed [15:0]    i_accel_z_raw,
    input  logic signed [15:0]    i_gyro_x_raw,
    input  logic signed [15:0]    i_gyro_y_raw,
    input  logic signed [15:0]    i_gyro_z_raw,
    input  logic signed [15:0]    i_bias_x,
    input  logic signed [15:0]    i_bias_y,
    input  logic signed [15:0]    i_bias_z,
    input  imucf_pkg::t_q_stat    i_q_stat,
    output imucf_pkg::t_push      o_push
);
    import imucf_pkg::*;

    assign o_ready = !i_q_stat.full;

    always_comb begin
        o_push.valid   = i_valid && !i_q_stat.full;
        o_push.item.ax = i_accel_x_raw;
        o_push.item.ay = i_accel_y_raw;
        o_push.item.az = i_accel_z_raw;
        o_push.item.gx = 17'(i_gyro_x_raw) - 17'(i_bias_x);
        o_push.item.gy = 17'(i_gyro_y_raw) - 17'(i_bias_y);
        o_push.item.gz = 17'(i_gyro_z_raw) - 17'(i_bias_z);
    end

endmodule

/* rtl/imucf_queue.sv */
// ----------------------------------------------------------------------------
// imucf_queue
// Two-entry queue between intake and the compute sequencer.
// ----------------------------------------------------------------------------
module imucf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imucf_pkg::t_push    i_push,
    input  logic                i_pop,
    output imucf_pkg::t_item    o_head,
    output imucf_pkg::t_q_stat  o_stat
);
    import imucf_pkg::*;

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        do_pop;

    assign do_pop      = i_pop && (r_cnt != 2'd0);
    assign o_head      = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(do_pop);
        end
    end

endmodule

/* rtl/imucf_div.sv */
// ----------------------------------------------------------------------------
// imucf_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imucf_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  imucf_pkg::t_div_req i_req,
    output imucf_pkg::t_div_rsp o_rsp
);
    import imucf_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             ge;

    assign ge        = (r_rem >= r_dsh);
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= i_req.dsh;
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/imucf_back.sv */
// ----------------------------------------------------------------------------
// imucf_back
// Compute sequencer: tilt angles, gyro integration, blend and result update.
// ----------------------------------------------------------------------------
module imucf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [15:0]          i_step_weight,
    input  imucf_pkg::t_item     i_head,
    input  imucf_pkg::t_q_stat   i_q_stat,
    output logic                 o_pop,
    output imucf_pkg::t_div_req  o_div_req,
    input  imucf_pkg::t_div_rsp  i_div_rsp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_angle_roll,
    output logic signed [31:0]   o_angle_pitch,
    output logic signed [31:0]   o_angle_yaw
);
    import imucf_pkg::*;

    localparam logic [37:0] RAD2DEG_Q32 = 38'd246083499208;
    localparam logic [18:0] R2D_LO      = RAD2DEG_Q32[18:0];
    localparam logic [18:0] R2D_HI      = RAD2DEG_Q32[37:19];
    localparam int          TILT_SH     = 17;
    localparam logic [CNT_W-1:0] TILT_ITERS = CNT_W'(TILT_SH + 1);
    // ceil(2^40 / 131), exact quotient for any 32-bit dividend
    localparam logic [32:0] GYRO_RCP    = 33'd8393218533;
    localparam logic [18:0] RCP_LO      = GYRO_RCP[18:0];
    localparam logic [13:0] RCP_HI      = GYRO_RCP[32:19];
    localparam logic signed [24:0] NINETY = 25'(90 << FRAC_BITS);

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    t_state             r_state, n_state;
    t_item              r_item;
    logic               r_axis;
    logic [1:0]         r_gidx;
    logic [31:0]        r_s;
    logic [31:0]        r_root;
    logic [30:0]        r_bit;
    logic [31:0]        r_md;
    logic [31:0]        r_dd;
    logic               r_big;
    logic [17:0]        r_q;
    logic [36:0]        r_rlo;
    logic [31:0]        r_y;
    logic [50:0]        r_glo;
    logic signed [24:0] r_acc [2];
    logic signed [33:0] r_g [3];
    logic signed [54:0] r_bpart;
    logic signed [33:0] r_f [2];
    logic signed [31:0] r_store [3];
    logic               r_first_done;
    logic signed [15:0] r_init;
    logic               r_ov;
    logic signed [54:0] r_prod;

    logic signed [34:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [54:0] mul_p;

    logic signed [16:0] t_n;
    logic               t_neg;
    logic [15:0]        t_m;
    logic signed [15:0] t_b;
    logic [15:0]        t_d;
    logic signed [16:0] g_diff;
    logic               g_neg;
    logic [15:0]        g_m;
    logic [31:0]        g_y;
    logic [45:0]        gq_sum;
    logic [24:0]        gq;
    logic [32:0]        sq_try;
    logic               sq_ge;
    logic [31:0]        m2;
    logic [36:0]        den_a, den_b, den;
    logic               big_now;
    logic [56:0]        raw57;
    logic signed [24:0] deg_mag, deg;
    logic signed [25:0] inc;
    logic signed [54:0] bsum;
    logic signed [31:0] r0;
    logic [32:0]        r0_mag;
    logic [16:0]        lat_mag;
    logic [16:0]        off_mag;
    logic               upd_go;

    // tilt operands: roll uses ay over (ax, az), pitch uses -ax over (ay, az)
    assign t_n   = r_axis ? -17'(r_item.ax) : 17'(r_item.ay);
    assign t_neg = t_n[16];
    assign t_m   = t_neg ? 16'(-t_n) : t_n[15:0];
    assign t_b   = r_axis ? r_item.ay : r_item.ax;
    assign t_d   = r_root[15:0];

    always_comb begin
        case (r_gidx)
            2'd0:    g_diff = r_item.gx;
            2'd1:    g_diff = r_item.gy;
            default: g_diff = r_item.gz;
        endcase
    end
    assign g_neg = g_diff[16];
    assign g_m   = g_neg ? 16'(-g_diff) : g_diff[15:0];

    // gyro scale: (|diff| * w + 65) / 131 by reciprocal multiply in two halves
    assign g_y    = r_prod[31:0] + 32'd65;
    assign gq_sum = r_prod[45:0] + 46'(r_glo[50:19]);
    assign gq     = gq_sum[45:21];

    assign sq_try = {1'b0, r_root} + {2'b0, r_bit};
    assign sq_ge  = ({1'b0, r_s} >= sq_try);

    assign m2      = r_prod[31:0];
    assign den_a   = {r_dd, 5'b0} + 37'(m2) + {2'b0, m2, 3'b0};
    assign den_b   = {m2, 5'b0} + 37'(r_dd) + {2'b0, r_dd, 3'b0};
    assign big_now = (t_m > t_d);
    assign den     = big_now ? den_b : den_a;

    assign raw57   = {1'b0, r_prod[36:0], 19'b0} + 57'(r_rlo) + 57'(64'd1 << 31);
    assign deg_mag = r_big ? (NINETY - raw57[56:32]) : raw57[56:32];
    assign deg     = t_neg ? -deg_mag : deg_mag;

    assign inc  = g_neg ? -{1'b0, gq} : {1'b0, gq};
    assign bsum = r_bpart + r_prod + 55'sd32768;

    assign r0      = sat32(36'(r_f[0]));
    assign r0_mag  = r0[31] ? -{r0[31], r0} : {1'b0, r0};
    assign lat_mag = r0_mag[32:16];
    assign off_mag = r_init[15] ? -{r_init[15], r_init} : {1'b0, r_init};
    assign upd_go  = !r_ov || i_ready;

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_q_stat.empty) n_state = S_SQB;
            S_SQB:   n_state = S_SQC;
            S_SQC:   n_state = S_SQSUM;
            S_SQSUM: n_state = S_SQRT;
            S_SQRT:  if (r_bit == 31'd1) n_state = S_MD;
            S_MD:    n_state = S_DD;
            S_DD:    n_state = S_MM;
            S_MM:    n_state = S_DEN;
            S_DEN:   n_state = S_TWAIT;
            S_TWAIT: if (i_div_rsp.done) n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = r_axis ? S_GM : S_SQB;
            S_GM:    n_state = S_GDIV;
            S_GDIV:  n_state = S_GWAIT;
            S_GWAIT: n_state = S_GSUM;
            S_GSUM:  n_state = (r_gidx == 2'd2) ? S_B0 : S_GM;
            S_B0:    n_state = S_B1;
            S_B1:    n_state = S_B2;
            S_B2:    n_state = r_axis ? S_UPD : S_B0;
            S_UPD:   if (upd_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // multiplier operands, queue pop and divider requests
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        o_pop     = 1'b0;
        o_div_req = '0;
        case (r_state)
            S_IDLE: o_pop = !i_q_stat.empty;
            S_SQB: begin
                mul_a = 35'(t_b);
                mul_b = 20'(t_b);
            end
            S_SQC: begin
                mul_a = 35'(r_item.az);
                mul_b = 20'(r_item.az);
            end
            S_MD: begin
                mul_a = {19'b0, t_m};
                mul_b = {4'b0, t_d};
            end
            S_DD: begin
                mul_a = {19'b0, t_d};
                mul_b = {4'b0, t_d};
            end
            S_MM: begin
                mul_a = {19'b0, t_m};
                mul_b = {4'b0, t_m};
            end
            S_DEN: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = (DIV_W'({r_md, 5'b0}) << FRAC_BITS) + DIV_W'(den >> 1);
                o_div_req.dsh   = DIV_W'(den) << TILT_SH;
                o_div_req.iters = TILT_ITERS;
            end
            S_RD0: begin
                mul_a = {17'b0, r_q};
                mul_b = {1'b0, R2D_LO};
            end
            S_RD1: begin
                mul_a = {17'b0, r_q};
                mul_b = {1'b0, R2D_HI};
            end
            S_GM: begin
                mul_a = {19'b0, g_m};
                mul_b = {4'b0, i_step_weight};
            end
            S_GDIV: begin
                mul_a = {3'b0, g_y};
                mul_b = {1'b0, RCP_LO};
            end
            S_GWAIT: begin
                mul_a = {3'b0, r_y};
                mul_b = {6'b0, RCP_HI};
            end
            S_B0: begin
                mul_a = 35'(r_g[r_axis]);
                mul_b = {3'b0, 17'h10000 - {1'b0, i_step_weight}};
            end
            S_B1: begin
                mul_a = 35'(r_acc[r_axis]);
                mul_b = {4'b0, i_step_weight};
            end
            default: ;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                r_item <= i_head;
                r_axis <= 1'b0;
            end
            S_SQC:   r_s <= r_prod[31:0];
            S_SQSUM: begin
                r_s    <= r_s + r_prod[31:0];
                r_root <= '0;
                r_bit  <= 31'h4000_0000;
            end
            S_SQRT: begin
                if (sq_ge) begin
                    r_s    <= r_s - sq_try[31:0];
                    r_root <= (r_root >> 1) + {1'b0, r_bit};
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_DD:    r_md <= r_prod[31:0];
            S_MM:    r_dd <= r_prod[31:0];
            S_DEN:   r_big <= big_now;
            // zero root: the ratio term is zero, both for 0/0 and for a pure vertical
            S_TWAIT: begin
                if (i_div_rsp.done) r_q <= (t_d == 16'd0) ? 18'd0 : i_div_rsp.quo[17:0];
            end
            S_RD1:   r_rlo <= r_prod[36:0];
            S_RD2: begin
                r_acc[r_axis] <= deg;
                r_axis        <= !r_axis;
                r_gidx        <= 2'd0;
            end
            S_GDIV:  r_y <= g_y;
            S_GWAIT: r_glo <= r_prod[50:0];
            S_GSUM: begin
                r_g[r_gidx] <= 34'(r_store[r_gidx]) + 34'(inc);
                r_gidx      <= r_gidx + 2'd1;
            end
            S_B1:    r_bpart <= r_prod;
            S_B2: begin
                r_f[r_axis] <= bsum[49:16];
                r_axis      <= !r_axis;
            end
            default: ;
        endcase
    end

    // state, stored angles and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_store[0]   <= '0;
            r_store[1]   <= '0;
            r_store[2]   <= '0;
            r_first_done <= 1'b0;
            r_init       <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD && upd_go) begin
                r_ov <= 1'b1;
                if (!r_first_done) begin
                    r_init       <= r0[31] ? 16'(-lat_mag) : lat_mag[15:0];
                    r_store[0]   <= r0;
                    r_first_done <= 1'b1;
                end else begin
                    r_store[0] <= sat32(36'(r_f[0]) - 36'({off_mag, 16'b0}));
                end
                r_store[1] <= sat32(36'(r_f[1]));
                r_store[2] <= sat32(36'(r_g[2]));
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_angle_roll  = r_store[0];
    assign o_angle_pitch = r_store[1];
    assign o_angle_yaw   = r_store[2];

endmodule

/* sim/imu_complementary_attitude_filter_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top_tb
// Drives raw IMU samples and config writes into the attitude filter, predicts
// roll, pitch and yaw for every sample and checks each result in order.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_filter_top_tb;
    import imucf_pkg::*;

    localparam int    WDOG_LIMIT = 40000;
    localparam longint RAD2DEG   = 64'd246083499208;

    typedef struct packed {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } t_angles;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_accel_x_raw, i_accel_y_raw, i_accel_z_raw;
    logic signed [15:0] i_gyro_x_raw, i_gyro_y_raw, i_gyro_z_raw;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_angle_roll, o_angle_pitch, o_angle_yaw;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;

    imu_complementary_attitude_filter_top u_dut (.*);

    // predictor state
    logic [15:0]        pr_weight;
    logic signed [15:0] pr_bias [3];
    logic signed [31:0] pr_angle [3];
    logic               pr_latched;
    logic signed [15:0] pr_first_deg;

    t_angles angle_q[$];
    int      n_err, n_samples, n_results, idle_cnt;
    bit      stall_long;
    bit      rx_busy_mode;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned div_near(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint unsigned to_deg(longint unsigned q);
        return (q * RAD2DEG + (64'd1 << 31)) >> 32;
    endfunction

    function automatic longint tilt(longint n, longint unsigned s);
        longint unsigned d, m, q;
        longint deg;
        d = int_sqrt(s);
        m = (n < 0) ? -n : n;
        if (m <= d) begin
            if (d == 0) return 0;
            q = div_near((32 * m * d) << FRAC_BITS, 32 * d * d + 9 * m * m);
            deg = longint'(to_deg(q));
        end else begin
            q = div_near((32 * m * d) << FRAC_BITS, 32 * m * m + 9 * d * d);
            deg = (longint'(90) << FRAC_BITS) - longint'(to_deg(q));
        end
        return (n < 0) ? -deg : deg;
    endfunction

    function automatic longint gyro_step(longint diff);
        longint unsigned m;
        longint v;
        m = (diff < 0) ? -diff : diff;
        v = longint'(div_near((m * pr_weight) << FRAC_BITS, 64'd131 * 64'd65536));
        return (diff < 0) ? -v : v;
    endfunction

    function automatic longint mix(longint g, longint a);
        longint w;
        w = longint'(pr_weight);
        return (g * (65536 - w) + a * w + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic predict_angles(input logic signed [15:0] s [6]);
        longint ax, ay, az, ar, ap, g0, g1, g2, f0, f1, v, off;
        longint unsigned m;
        t_angles e;
        ax = longint'(s[0]); ay = longint'(s[1]); az = longint'(s[2]);
        ar = tilt(ay, ax * ax + az * az);
        ap = tilt(-ax, ay * ay + az * az);
        g0 = longint'(pr_angle[0]) + gyro_step(longint'(s[3]) - pr_bias[0]);
        g1 = longint'(pr_angle[1]) + gyro_step(longint'(s[4]) - pr_bias[1]);
        g2 = longint'(pr_angle[2]) + gyro_step(longint'(s[5]) - pr_bias[2]);
        f0 = mix(g0, ar);
        f1 = mix(g1, ap);
        if (!pr_latched) begin
            v = longint'(clip32(f0));
            m = ((v < 0) ? -v : v) >> FRAC_BITS;
            if (v < 0) pr_first_deg = (m > 32768) ? -16'sd32768 : 16'(-m);
            else pr_first_deg = (m > 32767) ? 16'sd32767 : 16'(m);
            pr_angle[0] = 32'(v);
            pr_latched = 1'b1;
        end else begin
            off = longint'(pr_first_deg);
            if (off < 0) off = -off;
            pr_angle[0] = clip32(f0 - off * 65536);
        end
        pr_angle[1] = clip32(f1);
        pr_angle[2] = clip32(g2);
        e.roll = pr_angle[0]; e.pitch = pr_angle[1]; e.yaw = pr_angle[2];
        angle_q.push_back(e);
    endtask

    // valid stays high when the next sample follows at once
    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return;
        i_valid <= 1'b0;
        repeat ((r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 300)) @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] s [6]);
        i_valid       <= 1'b1;
        i_accel_x_raw <= s[0]; i_accel_y_raw <= s[1]; i_accel_z_raw <= s[2];
        i_gyro_x_raw  <= s[3]; i_gyro_y_raw  <= s[4]; i_gyro_z_raw  <= s[5];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_angles(s);
        n_samples++;
        random_gap();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_STEP_WEIGHT: pr_weight = val;
            REG_BIAS_X:      pr_bias[0] = val;
            REG_BIAS_Y:      pr_bias[1] = val;
            default:         pr_bias[2] = val;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd_field();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] s [6];
        logic signed [15:0] ext [5] = '{16'sh8000, 16'sh7fff, 0, 16'sd4096, -16'sd1};
        for (int i = 0; i < 5; i++) begin
            s = '{ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5],
                  ext[i], ext[(i + 3) % 5], ext[(i + 4) % 5]};
            send_sample(s);
        end
        s = '{0, 0, 0, 0, 0, 0};                 // zero denominator
        send_sample(s);
        s = '{0, 16'sd1000, 0, 16'sh7fff, 16'sh8000, 16'sh7fff};   // infinite ratio
        send_sample(s);
        s = '{0, -16'sd1000, 0, 16'sh8000, 16'sh7fff, 16'sh8000};
        send_sample(s);
        s = '{16'sd3000, 16'sd3000, 16'sd100, 1, 2, 3};            // |n| just below d, near the border
        send_sample(s);
        s = '{16'sd4096, 0, 0, 0, 0, 0};
        send_sample(s);
        drain();
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] s [6];
        repeat (count) begin
            foreach (s[k]) s[k] = rnd_field();
            send_sample(s);
        end
        drain();
    endtask

    task automatic test_config_sweep();
        logic [15:0] wv [4] = '{16'd0, 16'hffff, 16'd655, 16'd32768};
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_STEP_WEIGHT, wv[p]);
            write_reg(REG_BIAS_X, (p == 0) ? 16'h8000 : 16'($urandom));
            write_reg(REG_BIAS_Y, (p == 1) ? 16'h7fff : 16'($urandom));
            write_reg(REG_BIAS_Z, (p == 2) ? 16'h0000 : 16'($urandom));
            test_random(300);
        end
    endtask

    task automatic test_backpressure();
        logic signed [15:0] s [6];
        stall_long = 1'b1;
        repeat (6) begin
            foreach (s[k]) s[k] = 16'($urandom);
            i_valid       <= 1'b1;
            i_accel_x_raw <= s[0]; i_accel_y_raw <= s[1]; i_accel_z_raw <= s[2];
            i_gyro_x_raw  <= s[3]; i_gyro_y_raw  <= s[4]; i_gyro_z_raw  <= s[5];
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            predict_angles(s);
            n_samples++;
        end
        drain();
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (stall_long) begin
                i_ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                stall_long = 1'b0;
            end
            i_ready <= ($urandom_range(0, 3) != 0) || rx_busy_mode;
            @(posedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(50, 400)) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_angles e;
            n_results++;
            if (angle_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result transaction");
            end else begin
                e = angle_q.pop_front();
                if (e.roll !== o_angle_roll || e.pitch !== o_angle_pitch ||
                    e.yaw !== o_angle_yaw) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("result %0d: exp %0d %0d %0d got %0d %0d %0d", n_results,
                                 e.roll, e.pitch, e.yaw,
                                 o_angle_roll, o_angle_pitch, o_angle_yaw);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("imu_complementary_attitude_filter_top: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_accel_x_raw = '0; i_accel_y_raw = '0; i_accel_z_raw = '0;
        i_gyro_x_raw = '0; i_gyro_y_raw = '0; i_gyro_z_raw = '0;
        n_err = 0; n_samples = 0; n_results = 0; idle_cnt = 0;
        stall_long = 1'b0; rx_busy_mode = 1'b0;
        pr_weight = STEP_WEIGHT_RST; pr_bias = '{0, 0, 0};
        pr_angle = '{0, 0, 0}; pr_latched = 1'b0; pr_first_deg = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_backpressure();
        test_config_sweep();
        $display("samples sent %0d, results checked %0d, four config settings incl. extremes",
                 n_samples, n_results);
        if (n_err == 0) begin
            $display("imu_complementary_attitude_filter_top: match");
        end else begin
            $display("%0d mismatches", n_err);
            $display("imu_complementary_attitude_filter_top: mismatch");
        end
        $finish;
    end

endmodule
